// ----- rtl/mbpg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Moving box pattern generator package
// Shared widths, codes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package mbpg_pkg;

    localparam int CFG_W       = 12;
    localparam int CFG_ADDR_W  = 2;
    localparam int PIX_W       = 8;
    localparam int COORD_BITS  = 12;
    localparam int MODE_W      = 2;

    localparam logic [PIX_W-1:0] GREY = 8'd127;

    localparam logic [CFG_W-1:0] RST_PIC_WIDTH    = 12'd200;
    localparam logic [CFG_W-1:0] RST_PIC_HEIGHT   = 12'd100;
    localparam logic [CFG_W-1:0] RST_BOX_SIDE     = 12'd30;
    localparam logic [CFG_W-1:0] RST_STEP_SIZE    = 12'd17;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_MOVE  = 2'd2
    } t_mode;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PIC_WIDTH    = 2'd0,
        REG_PIC_HEIGHT   = 2'd1,
        REG_BOX_SIDE     = 2'd2,
        REG_STEP_SIZE    = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        HEAD_RIGHT      = 3'd0,
        HEAD_DOWN_LEFT  = 3'd1,
        HEAD_LEFT       = 3'd2,
        HEAD_DOWN_RIGHT = 3'd3,
        HEAD_UP_LEFT    = 3'd4,
        HEAD_UP_RIGHT   = 3'd5
    } t_heading;

    typedef struct packed {
        logic [CFG_W-1:0] pic_width;
        logic [CFG_W-1:0] pic_height;
        logic [CFG_W-1:0] box_side;
        logic [CFG_W-1:0] step_size;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } t_colour;

endpackage
`default_nettype wire

// ----- rtl/mbpg_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Frame size, box side and step size, written through a plain write port.
// ----------------------------------------------------------------------------
module mbpg_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mbpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [mbpg_pkg::CFG_W-1:0]      i_cfg_wdata,
    output mbpg_pkg::t_cfg                      o_cfg
);

    mbpg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pic_width    <= mbpg_pkg::RST_PIC_WIDTH;
            r_cfg.pic_height   <= mbpg_pkg::RST_PIC_HEIGHT;
            r_cfg.box_side     <= mbpg_pkg::RST_BOX_SIDE;
            r_cfg.step_size    <= mbpg_pkg::RST_STEP_SIZE;
        end else if (i_cfg_we) begin
            case (mbpg_pkg::t_reg_idx'(i_cfg_addr))
                mbpg_pkg::REG_PIC_WIDTH:    r_cfg.pic_width    <= i_cfg_wdata;
                mbpg_pkg::REG_PIC_HEIGHT:   r_cfg.pic_height   <= i_cfg_wdata;
                mbpg_pkg::REG_BOX_SIDE:     r_cfg.box_side     <= i_cfg_wdata;
                mbpg_pkg::REG_STEP_SIZE:    r_cfg.step_size    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- rtl/mbpg_pixel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel colour lookup
// Decides box membership of a luma pixel and of its 2x2 chroma block.
// ----------------------------------------------------------------------------
module mbpg_pixel #(
    parameter int COORD_BITS = mbpg_pkg::COORD_BITS
) (
    input  wire logic [COORD_BITS-1:0]        i_px,
    input  wire logic [COORD_BITS-1:0]        i_py,
    input  wire logic [COORD_BITS-1:0]        i_left,
    input  wire logic [COORD_BITS-1:0]        i_top,
    input  wire logic [mbpg_pkg::CFG_W-1:0]   i_side,
    input  wire mbpg_pkg::t_colour            i_colour,
    output mbpg_pkg::t_colour                 o_colour,
    output logic                              o_in_box
);

    localparam int CALC_W = ((COORD_BITS > mbpg_pkg::CFG_W) ? COORD_BITS : mbpg_pkg::CFG_W) + 2;

    logic [CALC_W-1:0] w_px, w_py, w_cx, w_cy, w_left, w_top, w_right, w_bottom;
    logic              w_pin, w_cin;

    always_comb begin
        w_px     = CALC_W'(i_px);
        w_py     = CALC_W'(i_py);
        // Chroma block origin is the even luma coordinate.
        w_cx     = CALC_W'({i_px[COORD_BITS-1:1], 1'b0});
        w_cy     = CALC_W'({i_py[COORD_BITS-1:1], 1'b0});
        w_left   = CALC_W'(i_left);
        w_top    = CALC_W'(i_top);
        w_right  = w_left + CALC_W'(i_side);
        w_bottom = w_top + CALC_W'(i_side);

        w_pin = (w_px >= w_left) && (w_px < w_right) &&
                (w_py >= w_top) && (w_py < w_bottom);
        w_cin = (w_cx + CALC_W'(2) > w_left) && (w_cx < w_right) &&
                (w_cy + CALC_W'(2) > w_top) && (w_cy < w_bottom);

        o_in_box      = w_pin;
        o_colour.luma = w_pin ? i_colour.luma : mbpg_pkg::GREY;
        o_colour.cb   = w_cin ? i_colour.cb : mbpg_pkg::GREY;
        o_colour.cr   = w_cin ? i_colour.cr : mbpg_pkg::GREY;
    end

endmodule
`default_nettype wire

// ----- rtl/mbpg_motion.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Box motion and colour state
// Holds box position, heading, phase and colour; steps the serpentine path.
// ----------------------------------------------------------------------------
module mbpg_motion #(
    parameter int COORD_BITS = mbpg_pkg::COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [mbpg_pkg::MODE_W-1:0]  i_mode,
    input  wire mbpg_pkg::t_colour            i_new_colour,
    input  wire mbpg_pkg::t_cfg               i_cfg,
    output logic [COORD_BITS-1:0]             o_left,
    output logic [COORD_BITS-1:0]             o_top,
    output logic [COORD_BITS-1:0]             o_next_left,
    output logic [COORD_BITS-1:0]             o_next_top,
    output mbpg_pkg::t_colour                 o_colour
);

    localparam int CALC_W = ((COORD_BITS > mbpg_pkg::CFG_W) ? COORD_BITS : mbpg_pkg::CFG_W) + 2;

    logic [COORD_BITS-1:0] r_left, r_top, n_left, n_top;
    mbpg_pkg::t_heading    r_heading, n_heading, w_head;
    logic                  r_phase, n_phase;
    mbpg_pkg::t_colour     r_colour;

    logic                  w_move, w_load, w_vert;
    logic [CALC_W-1:0]     w_side, w_step, w_fwd_pos, w_fwd_lim, w_edge, w_ret_pos;
    logic                  w_fits, w_sat;
    logic [COORD_BITS-1:0] w_adv_new, w_ret_new;
    logic                  w_chk_corner, w_chk_origin, w_corner, w_origin;

    assign w_move = i_en && (mbpg_pkg::t_mode'(i_mode) == mbpg_pkg::MODE_MOVE);
    assign w_load = i_en && (mbpg_pkg::t_mode'(i_mode) == mbpg_pkg::MODE_LOAD);

    // Fold the stored heading onto the cases the current phase knows.
    always_comb begin
        case (r_heading)
            mbpg_pkg::HEAD_RIGHT, mbpg_pkg::HEAD_LEFT: w_head = r_heading;
            mbpg_pkg::HEAD_DOWN_LEFT, mbpg_pkg::HEAD_UP_LEFT:
                w_head = r_phase ? mbpg_pkg::HEAD_UP_LEFT : mbpg_pkg::HEAD_DOWN_LEFT;
            mbpg_pkg::HEAD_DOWN_RIGHT, mbpg_pkg::HEAD_UP_RIGHT:
                w_head = r_phase ? mbpg_pkg::HEAD_UP_RIGHT : mbpg_pkg::HEAD_DOWN_RIGHT;
            default: w_head = mbpg_pkg::HEAD_RIGHT;
        endcase
    end

    assign w_vert = (w_head != mbpg_pkg::HEAD_RIGHT) && (w_head != mbpg_pkg::HEAD_LEFT);

    // One shared forward unit and one shared backward unit.
    always_comb begin
        w_side    = CALC_W'(i_cfg.box_side);
        w_step    = CALC_W'(i_cfg.step_size);
        w_fwd_pos = w_vert ? CALC_W'(r_top) : CALC_W'(r_left);
        w_fwd_lim = w_vert ? CALC_W'(i_cfg.pic_height) : CALC_W'(i_cfg.pic_width);
        w_fits    = (w_fwd_pos + w_side + w_step) <= w_fwd_lim;
        w_edge    = (w_fwd_lim > w_side) ? (w_fwd_lim - w_side) : '0;
        w_adv_new = w_fits ? COORD_BITS'(w_fwd_pos + w_step) : COORD_BITS'(w_edge);

        w_ret_pos = w_vert ? CALC_W'(r_top) : CALC_W'(r_left);
        w_sat     = w_ret_pos < w_step;
        w_ret_new = w_sat ? '0 : COORD_BITS'(w_ret_pos - w_step);
    end

    always_comb begin
        n_left       = r_left;
        n_top        = r_top;
        n_heading    = r_heading;
        w_chk_corner = 1'b0;
        w_chk_origin = 1'b0;
        case (w_head)
            mbpg_pkg::HEAD_RIGHT: begin
                n_left = w_adv_new;
                if (!w_fits) begin
                    n_heading = r_phase ? mbpg_pkg::HEAD_UP_LEFT : mbpg_pkg::HEAD_DOWN_LEFT;
                end
                w_chk_corner = !r_phase;
            end
            mbpg_pkg::HEAD_DOWN_LEFT: begin
                n_heading    = mbpg_pkg::HEAD_LEFT;
                n_top        = w_adv_new;
                w_chk_corner = 1'b1;
            end
            mbpg_pkg::HEAD_DOWN_RIGHT: begin
                n_heading = mbpg_pkg::HEAD_RIGHT;
                n_top     = w_adv_new;
            end
            mbpg_pkg::HEAD_UP_LEFT: begin
                n_heading = mbpg_pkg::HEAD_LEFT;
                n_top     = w_ret_new;
            end
            mbpg_pkg::HEAD_UP_RIGHT: begin
                n_heading    = mbpg_pkg::HEAD_RIGHT;
                n_top        = w_ret_new;
                w_chk_origin = 1'b1;
            end
            default: begin
                n_left = w_ret_new;
                if (w_sat) begin
                    n_heading = r_phase ? mbpg_pkg::HEAD_UP_RIGHT : mbpg_pkg::HEAD_DOWN_RIGHT;
                end
                w_chk_origin = r_phase;
            end
        endcase
    end

    assign w_corner = (CALC_W'(n_left) + w_side == CALC_W'(i_cfg.pic_width)) &&
                      (CALC_W'(n_top) + w_side == CALC_W'(i_cfg.pic_height));
    assign w_origin = (n_left == '0) && (n_top == '0);

    always_comb begin
        n_phase = r_phase;
        if (w_chk_corner && w_corner) begin
            n_phase = 1'b1;
        end else if (w_chk_origin && w_origin) begin
            n_phase = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_top     <= '0;
            r_heading <= mbpg_pkg::HEAD_RIGHT;
            r_phase   <= 1'b0;
            r_colour  <= '0;
        end else begin
            if (w_move) begin
                r_left    <= n_left;
                r_top     <= n_top;
                r_heading <= n_heading;
                r_phase   <= n_phase;
            end
            if (w_load) begin
                r_colour <= i_new_colour;
            end
        end
    end

    assign o_left      = r_left;
    assign o_top       = r_top;
    assign o_next_left = w_move ? n_left : r_left;
    assign o_next_top  = w_move ? n_top : r_top;
    assign o_colour    = r_colour;

`ifndef SYNTHESIS
    // The return phase only starts once the box sits in the far corner.
    a_phase_rise_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase) |->
            (CALC_W'(r_left) + CALC_W'($past(i_cfg.box_side)) ==
             CALC_W'($past(i_cfg.pic_width))) &&
            (CALC_W'(r_top) + CALC_W'($past(i_cfg.box_side)) ==
             CALC_W'($past(i_cfg.pic_height))))
        else $error("return phase started away from the far corner");

    // The downward phase only resumes at the origin.
    a_phase_fall_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_phase) |-> (r_left == '0) && (r_top == '0))
        else $error("downward phase resumed away from the origin");

    // Position changes only through a move.
    a_pos_only_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_move |=> $stable(r_left) && $stable(r_top))
        else $error("box position changed without a move");
`endif

endmodule
`default_nettype wire

// ----- rtl/moving_box_pattern_generator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Moving box pattern generator
// Serves pixel queries, colour loads and frame moves for a moving box pattern.
// ----------------------------------------------------------------------------
// Timing: an accepted item passes through the input register and then the
// output register before o_m_tvalid offers its result.
// Throughput: one item per cycle while i_m_tready stays high; the input register
// and the output register each hold one item, so one item is taken while a result waits.
// Reset: synchronous, active low; clears both valid flags, the box position,
// heading, phase and colour, and loads the default frame, box and step sizes.
module moving_box_pattern_generator_unit #(
    parameter  int COORD_BITS = mbpg_pkg::COORD_BITS,
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 3 * mbpg_pkg::PIX_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((3 * mbpg_pkg::PIX_W + 1 + 2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Slave side
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: pixel_x, pixel_y, new_luma, new_cb, new_cr (from bit 0 up)
    input  wire logic [IN_DATA_W-1:0]            i_s_tdata,
    // tuser: mode
    input  wire logic [mbpg_pkg::MODE_W-1:0]     i_s_tuser,
    // Master side
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // tdata: luma_out, cb_out, cr_out, in_box, box_col, box_row, zero fill
    output logic [OUT_DATA_W-1:0]                o_m_tdata,
    // Configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [mbpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [mbpg_pkg::CFG_W-1:0]      i_cfg_wdata
);

    localparam int PW         = mbpg_pkg::PIX_W;
    localparam int OUT_RAW_W  = 3 * PW + 1 + 2 * COORD_BITS;

    mbpg_pkg::t_cfg            w_cfg;

    logic                      r_in_valid;
    logic [mbpg_pkg::MODE_W-1:0] r_mode;
    logic [COORD_BITS-1:0]     r_px, r_py;
    mbpg_pkg::t_colour         r_new_colour;

    logic                      r_out_valid;
    logic [OUT_RAW_W-1:0]      r_out_data;

    logic                      w_adv, w_query, w_in_box;
    logic [COORD_BITS-1:0]     w_left, w_top, w_next_left, w_next_top;
    mbpg_pkg::t_colour         w_colour, w_pix_colour, w_res_colour;
    logic [OUT_RAW_W-1:0]      n_out_data;

    // An item leaves the input register when the output register is free or drains.
    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_mode            <= i_s_tuser;
            r_px              <= i_s_tdata[COORD_BITS-1:0];
            r_py              <= i_s_tdata[2*COORD_BITS-1:COORD_BITS];
            r_new_colour.luma <= i_s_tdata[2*COORD_BITS+PW-1:2*COORD_BITS];
            r_new_colour.cb   <= i_s_tdata[2*COORD_BITS+2*PW-1:2*COORD_BITS+PW];
            r_new_colour.cr   <= i_s_tdata[2*COORD_BITS+3*PW-1:2*COORD_BITS+2*PW];
        end
    end

    mbpg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    mbpg_motion #(.COORD_BITS(COORD_BITS)) u_motion (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_mode       (r_mode),
        .i_new_colour (r_new_colour),
        .i_cfg        (w_cfg),
        .o_left       (w_left),
        .o_top        (w_top),
        .o_next_left  (w_next_left),
        .o_next_top   (w_next_top),
        .o_colour     (w_colour)
    );

    mbpg_pixel #(.COORD_BITS(COORD_BITS)) u_pixel (
        .i_px     (r_px),
        .i_py     (r_py),
        .i_left   (w_left),
        .i_top    (w_top),
        .i_side   (w_cfg.box_side),
        .i_colour (w_colour),
        .o_colour (w_pix_colour),
        .o_in_box (w_in_box)
    );

    // Pixel fields are zero for everything but a query.
    assign w_query      = mbpg_pkg::t_mode'(r_mode) == mbpg_pkg::MODE_QUERY;
    assign w_res_colour = w_query ? w_pix_colour : '0;
    assign n_out_data   = {w_next_top, w_next_left, w_query && w_in_box,
                           w_res_colour.cr, w_res_colour.cb, w_res_colour.luma};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out_data);

`ifndef SYNTHESIS
    // Nothing is offered downstream in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !r_in_valid)
        else $error("valid flags not cleared by reset");

    // A held item stays in the input register until it moves on.
    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid && $stable(r_mode))
        else $error("pending item lost from the input register");

    // Both stages full and stalled means no new transfer is taken.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("transfer taken while both stages are full");
`endif

endmodule
`default_nettype wire

// ----- tb/moving_box_pattern_generator_unit_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Moving box pattern generator testbench
// Drives colour loads, pixel queries, frame moves and ignored items through
// the stream ports, under several frame, box and step settings. A scoreboard
// tracks the box on its serpentine path, predicts every result and checks
// each one in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module moving_box_pattern_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W = 48;
    localparam int OUT_W = 56;
    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 125;
    // Mode code that the block takes and answers but otherwise ignores.
    localparam logic [mbpg_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;

    // Request fields, lowest bits last in the list.
    typedef struct packed {
        logic [7:0]  cr;
        logic [7:0]  cb;
        logic [7:0]  luma;
        logic [11:0] y;
        logic [11:0] x;
    } t_pattern_request;

    typedef struct packed {
        logic [6:0]  fill;
        logic [11:0] row;
        logic [11:0] col;
        logic        in_box;
        logic [7:0]  cr;
        logic [7:0]  cb;
        logic [7:0]  luma;
    } t_pixel_result;

    class t_box_scoreboard;
        int width;
        int height;
        int side;
        int step;
        int left;
        int top;
        mbpg_pkg::t_heading heading;
        bit returning;
        logic [7:0] box_luma;
        logic [7:0] box_cb;
        logic [7:0] box_cr;
        t_pixel_result expected_px[$];
        int mismatches;

        function new();
            width = int'(mbpg_pkg::RST_PIC_WIDTH);
            height = int'(mbpg_pkg::RST_PIC_HEIGHT);
            side = int'(mbpg_pkg::RST_BOX_SIDE);
            step = int'(mbpg_pkg::RST_STEP_SIZE);
            left = 0;
            top = 0;
            heading = mbpg_pkg::HEAD_RIGHT;
            returning = 1'b0;
            box_luma = '0;
            box_cb = '0;
            box_cr = '0;
            mismatches = 0;
        endfunction

        function void set_reg(mbpg_pkg::t_reg_idx idx, int value);
            case (idx)
                mbpg_pkg::REG_PIC_WIDTH: width = value;
                mbpg_pkg::REG_PIC_HEIGHT: height = value;
                mbpg_pkg::REG_BOX_SIDE: side = value;
                mbpg_pkg::REG_STEP_SIZE: step = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_px.size();
        endfunction

        function bit at_far_corner();
            return (left + side == width) && (top + side == height);
        endfunction

        // A forward move that would overrun the edge clamps the box against it.
        function int forward_pos(int pos, int limit);
            if (pos + side + step <= limit) return pos + step;
            return (limit > side) ? limit - side : 0;
        endfunction

        function int backward_pos(int pos);
            return (pos >= step) ? pos - step : 0;
        endfunction

        function void move_box();
            mbpg_pkg::t_heading h;
            bit blocked;
            h = heading;
            if (!returning) begin
                if (h == mbpg_pkg::HEAD_UP_LEFT) h = mbpg_pkg::HEAD_DOWN_LEFT;
                if (h == mbpg_pkg::HEAD_UP_RIGHT) h = mbpg_pkg::HEAD_DOWN_RIGHT;
                case (h)
                    mbpg_pkg::HEAD_RIGHT: begin
                        blocked = left + side + step > width;
                        left = forward_pos(left, width);
                        if (blocked) heading = mbpg_pkg::HEAD_DOWN_LEFT;
                        if (at_far_corner()) returning = 1'b1;
                    end
                    mbpg_pkg::HEAD_DOWN_LEFT: begin
                        heading = mbpg_pkg::HEAD_LEFT;
                        top = forward_pos(top, height);
                        if (at_far_corner()) returning = 1'b1;
                    end
                    mbpg_pkg::HEAD_DOWN_RIGHT: begin
                        heading = mbpg_pkg::HEAD_RIGHT;
                        top = forward_pos(top, height);
                    end
                    default: begin
                        blocked = left < step;
                        left = backward_pos(left);
                        if (blocked) heading = mbpg_pkg::HEAD_DOWN_RIGHT;
                    end
                endcase
            end else begin
                if (h == mbpg_pkg::HEAD_DOWN_LEFT) h = mbpg_pkg::HEAD_UP_LEFT;
                if (h == mbpg_pkg::HEAD_DOWN_RIGHT) h = mbpg_pkg::HEAD_UP_RIGHT;
                case (h)
                    mbpg_pkg::HEAD_RIGHT: begin
                        blocked = left + side + step > width;
                        left = forward_pos(left, width);
                        if (blocked) heading = mbpg_pkg::HEAD_UP_LEFT;
                    end
                    mbpg_pkg::HEAD_UP_LEFT: begin
                        heading = mbpg_pkg::HEAD_LEFT;
                        top = backward_pos(top);
                    end
                    mbpg_pkg::HEAD_UP_RIGHT: begin
                        heading = mbpg_pkg::HEAD_RIGHT;
                        top = backward_pos(top);
                        if (left == 0 && top == 0) returning = 1'b0;
                    end
                    default: begin
                        blocked = left < step;
                        left = backward_pos(left);
                        if (blocked) heading = mbpg_pkg::HEAD_UP_RIGHT;
                        if (left == 0 && top == 0) returning = 1'b0;
                    end
                endcase
            end
        endfunction

        function void note_request(logic [mbpg_pkg::MODE_W-1:0] mode, t_pattern_request req);
            t_pixel_result r;
            int x;
            int y;
            int cx;
            int cy;
            bit pix_in;
            bit blk_in;
            r = '0;
            x = int'(req.x);
            y = int'(req.y);
            case (mode)
                mbpg_pkg::MODE_LOAD: begin
                    box_luma = req.luma;
                    box_cb = req.cb;
                    box_cr = req.cr;
                end
                mbpg_pkg::MODE_QUERY: begin
                    // Chroma covers the 2x2 block that starts at the even corner.
                    cx = x & ~1;
                    cy = y & ~1;
                    pix_in = (x + 1 > left) && (x < left + side)
                          && (y + 1 > top) && (y < top + side);
                    blk_in = (cx + 2 > left) && (cx < left + side)
                          && (cy + 2 > top) && (cy < top + side);
                    r.in_box = pix_in;
                    r.luma = pix_in ? box_luma : mbpg_pkg::GREY;
                    r.cb = blk_in ? box_cb : mbpg_pkg::GREY;
                    r.cr = blk_in ? box_cr : mbpg_pkg::GREY;
                end
                mbpg_pkg::MODE_MOVE: move_box();
                default: ;
            endcase
            r.col = left[11:0];
            r.row = top[11:0];
            expected_px.push_back(r);
        endfunction

        function void check_result(t_pixel_result got);
            t_pixel_result want;
            if (expected_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %h", $realtime, got);
                return;
            end
            want = expected_px.pop_front();
            if (got.luma !== want.luma || got.cb !== want.cb || got.cr !== want.cr
                    || got.in_box !== want.in_box || got.col !== want.col
                    || got.row !== want.row || got.fill !== want.fill) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected y %0d u %0d v %0d in %0d col %0d row %0d fill %0d",
                             $realtime, want.luma, want.cb, want.cr, want.in_box,
                             want.col, want.row, want.fill);
                    $display("%0t:      got y %0d u %0d v %0d in %0d col %0d row %0d fill %0d",
                             $realtime, got.luma, got.cb, got.cr, got.in_box,
                             got.col, got.row, got.fill);
                end
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [IN_W-1:0]                 i_s_tdata = '0;
    logic [mbpg_pkg::MODE_W-1:0]     i_s_tuser = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [OUT_W-1:0]                o_m_tdata;
    logic                            i_cfg_we = 1'b0;
    logic [mbpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [mbpg_pkg::CFG_W-1:0]      i_cfg_wdata = '0;

    t_box_scoreboard sb;
    bit calm = 1'b0;
    int quiet_cycles = 0;

    moving_box_pattern_generator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Results are checked before the input of the same edge is noted, so a
    // result can never be matched against an item that has only just gone in.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if (i_s_tvalid && o_s_tready) sb.note_request(i_s_tuser, i_s_tdata);
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("moving_box_pattern_generator_unit_test: errors");
                $finish;
            end
        end
    end

    // Output stalls come in bursts, with open stretches in between.
    always begin
        @(negedge i_clk);
        if (i_rst_n && !calm && $urandom_range(0, 9) == 0) begin
            i_m_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_m_tready <= 1'b1;
    end

    task automatic push_item(input logic [mbpg_pkg::MODE_W-1:0] mode,
                             input t_pattern_request req);
        int gap;
        gap = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= req;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic push_fields(input logic [mbpg_pkg::MODE_W-1:0] mode, input int x,
                               input int y, input int luma, input int cb, input int cr);
        t_pattern_request req;
        req.x = 12'(x);
        req.y = 12'(y);
        req.luma = 8'(luma);
        req.cb = 8'(cb);
        req.cr = 8'(cr);
        push_item(mode, req);
    endtask

    // Holds the input back until every result is out.
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_frame(input int w, input int h, input int s, input int st);
        int vals[4];
        vals = '{w, h, s, st};
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_addr <= mbpg_pkg::t_reg_idx'(i);
            i_cfg_wdata <= mbpg_pkg::CFG_W'(vals[i]);
            @(posedge i_clk);
            sb.set_reg(mbpg_pkg::t_reg_idx'(i), vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Keeps a query coordinate close to the box span so both edges get hit.
    function automatic int near_span(int start, int side);
        int v;
        v = start - 3 + $urandom_range(0, side + 6);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    task automatic push_random();
        logic [63:0] raw;
        t_pattern_request req;
        int roll;
        logic [mbpg_pkg::MODE_W-1:0] mode;
        raw = {$urandom(), $urandom()};
        req = raw[IN_W-1:0];
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            mode = MODE_IGNORED;
        end else if (roll < 10) begin
            mode = mbpg_pkg::MODE_LOAD;
        end else if (roll < 32) begin
            mode = mbpg_pkg::MODE_MOVE;
        end else begin
            mode = mbpg_pkg::MODE_QUERY;
            if ($urandom_range(0, 7) != 0) begin
                req.x = 12'(near_span(sb.left, sb.side));
                req.y = 12'(near_span(sb.top, sb.side));
            end
        end
        push_item(mode, req);
    endtask

    initial begin
        int w;
        int h;
        int s;
        int st;
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default frame 200x100, box 30, step 17, box at the origin.
        push_fields(MODE_IGNORED, 4095, 4095, 255, 255, 255);
        push_fields(mbpg_pkg::MODE_QUERY, 0, 0, 255, 255, 255);
        push_fields(mbpg_pkg::MODE_LOAD, 4095, 4095, 255, 255, 255);
        push_fields(mbpg_pkg::MODE_QUERY, 0, 0, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_QUERY, 29, 29, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_QUERY, 30, 0, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_QUERY, 0, 30, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_QUERY, 4095, 4095, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_QUERY, 4095, 0, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_MOVE, 0, 0, 0, 0, 0);
        // Box now spans columns 17 to 46: odd edges give chroma without luma.
        push_fields(mbpg_pkg::MODE_QUERY, 16, 0, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_QUERY, 47, 29, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_QUERY, 17, 0, 0, 0, 0);
        push_fields(MODE_IGNORED, 0, 0, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_LOAD, 0, 0, 0, 0, 0);
        push_fields(mbpg_pkg::MODE_QUERY, 20, 10, 255, 255, 255);
        push_fields(mbpg_pkg::MODE_LOAD, 0, 0, 200, 16, 240);
        repeat (8) push_fields(mbpg_pkg::MODE_MOVE, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 40);
            s = $urandom_range(1, (w < h) ? w : h);
            st = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 12);
            case (phase)
                0: begin w = 4095; h = 4095; s = 1; st = 4095; end
                1: begin w = 1; h = 1; s = 1; st = 1; end
                3: begin w = 40; h = 24; s = 7; st = 5; end
                5: begin w = 4095; h = 2; s = 2; st = 1; end
                default: ;
            endcase
            drain();
            program_frame(w, h, s, st);
            if (phase == NUM_PHASES - 1) calm = 1'b1;
            repeat (ITEMS_PER_PHASE) push_random();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("moving_box_pattern_generator_unit_test: clean");
        else
            $display("moving_box_pattern_generator_unit_test: errors");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/mbpg_pkg.sv
rtl/mbpg_cfg.sv
rtl/mbpg_pixel.sv
rtl/mbpg_motion.sv
rtl/moving_box_pattern_generator_unit.sv
tb/moving_box_pattern_generator_unit_test.sv
